FILE: hw/rtl/pmid_pkg.sv
// ----------------------------------------------------------------------------
// pmid_pkg
// Types and constants shared by the periodic minimum-image distance unit:
// coordinate widths, payload structures and the inter-stage structures.
// ----------------------------------------------------------------------------
package pmid_pkg;

  // Coordinate and derived arithmetic widths.
  localparam int COORD_BITS  = 24;
  localparam int PERIOD_BITS = COORD_BITS + 1;
  localparam int SQUARE_BITS = 2 * COORD_BITS;
  // Room for the sum of up to three squares.
  localparam int SUM_BITS    = SQUARE_BITS + 2;
  localparam int LIMSQ_BITS  = 2 * PERIOD_BITS;
  localparam int MAX_AXES    = 3;

  // Five front stages, one stage per root bit and the output register.
  localparam int LATENCY     = COORD_BITS + 6;

  // The period resets to 1.0 in the fixed-point scale.
  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(1) << COORD_BITS;

  typedef logic [COORD_BITS-1:0]  coord_t;
  typedef logic [PERIOD_BITS-1:0] period_t;

  // One input item: the two points.
  typedef struct packed {
    coord_t first_x;
    coord_t first_y;
    coord_t first_z;
    coord_t second_x;
    coord_t second_y;
    coord_t second_z;
  } pmid_in_t;

  // One result item.
  typedef struct packed {
    coord_t distance;
    logic   over_half;
  } pmid_out_t;

  // Front end to square-root pipeline.
  typedef struct packed {
    logic                   valid;
    logic                   over_half;
    logic                   saturate;
    logic [SQUARE_BITS-1:0] radicand;
  } pmid_rad_t;

  // Square-root pipeline to output register.
  typedef struct packed {
    logic   valid;
    logic   over_half;
    logic   saturate;
    coord_t root;
  } pmid_root_t;

endpackage

FILE: hw/rtl/pmid_front.sv
// ----------------------------------------------------------------------------
// pmid_front
// Five-stage front end: absolute difference, minimum-image fold, squaring,
// summation, then the half-period test and the saturation check.
// ----------------------------------------------------------------------------
module pmid_front #(
  parameter int DIMENSIONS = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  pmid_pkg::pmid_in_t  in_item,
  input  pmid_pkg::period_t   period,
  output pmid_pkg::pmid_rad_t rad
);

  localparam int CB = pmid_pkg::COORD_BITS;
  localparam int PB = pmid_pkg::PERIOD_BITS;
  localparam int QB = pmid_pkg::SQUARE_BITS;
  localparam int SB = pmid_pkg::SUM_BITS;
  localparam int LB = pmid_pkg::LIMSQ_BITS;

  pmid_pkg::coord_t first_c  [pmid_pkg::MAX_AXES];
  pmid_pkg::coord_t second_c [pmid_pkg::MAX_AXES];

  // Stage registers.
  logic              s1_valid;
  pmid_pkg::coord_t  s1_diff [DIMENSIONS];
  pmid_pkg::period_t s1_lim;
  logic              s2_valid;
  pmid_pkg::coord_t  s2_fold [DIMENSIONS];
  pmid_pkg::period_t s2_lim;
  logic              s3_valid;
  logic [QB-1:0]     s3_sq [DIMENSIONS];
  logic [LB-1:0]     s3_limsq;
  logic              s4_valid;
  logic [SB-1:0]     s4_sum;
  logic [LB-1:0]     s4_limsq;

  logic [SB-1:0]     sum_next;

  // Axis views of the input item.
  assign first_c[0]  = in_item.first_x;
  assign first_c[1]  = in_item.first_y;
  assign first_c[2]  = in_item.first_z;
  assign second_c[0] = in_item.second_x;
  assign second_c[1] = in_item.second_y;
  assign second_c[2] = in_item.second_z;

  // Valid bits travel with the data through the first four stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
    end
  end

  // One lane per axis for the first three stages.
  for (genvar i = 0; i < DIMENSIONS; i++) begin : g_lane
    logic [PB-1:0] diff_ext;
    logic [PB-1:0] fold_val;

    assign diff_ext = {1'b0, s1_diff[i]};

    // Past half a period the fold is |period - difference|, else the difference.
    always_comb begin
      if ({s1_diff[i], 1'b0} > s1_lim) begin
        if (s1_lim >= diff_ext) begin
          fold_val = s1_lim - diff_ext;
        end else begin
          fold_val = diff_ext - s1_lim;
        end
      end else begin
        fold_val = diff_ext;
      end
    end

    always_ff @(posedge clk) begin
      if (first_c[i] >= second_c[i]) begin
        s1_diff[i] <= first_c[i] - second_c[i];
      end else begin
        s1_diff[i] <= second_c[i] - first_c[i];
      end
      s2_fold[i] <= fold_val[CB-1:0];
      s3_sq[i]   <= QB'(s2_fold[i]) * QB'(s2_fold[i]);
    end
  end

  // Sum of the squared components over the active axes.
  always_comb begin
    sum_next = '0;
    for (int i = 0; i < DIMENSIONS; i++) begin
      sum_next = sum_next + SB'(s3_sq[i]);
    end
  end

  // Period travels with the item, squared alongside the components; the last
  // stage also carries the valid bit of the item.
  always_ff @(posedge clk) begin
    s1_lim        <= period;
    s2_lim        <= s1_lim;
    s3_limsq      <= LB'(s2_lim) * LB'(s2_lim);
    s4_sum        <= sum_next;
    s4_limsq      <= s3_limsq;
    rad.over_half <= {s4_sum, 2'b00} > (SB + 2)'(s4_limsq);
    rad.saturate  <= |s4_sum[SB-1:QB];
    rad.radicand  <= s4_sum[QB-1:0];
    if (rst) begin
      rad.valid <= 1'b0;
    end else begin
      rad.valid <= s4_valid;
    end
  end

endmodule

FILE: hw/rtl/pmid_sqrt.sv
// ----------------------------------------------------------------------------
// pmid_sqrt
// Pipelined integer square root: one restoring step, and so one root bit,
// per register stage, with the flags of the item carried alongside.
// ----------------------------------------------------------------------------
module pmid_sqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  pmid_pkg::pmid_rad_t  rad,
  output pmid_pkg::pmid_root_t root
);

  localparam int N     = pmid_pkg::COORD_BITS;
  localparam int REM_W = N + 2;

  typedef struct packed {
    logic             valid;
    logic             over_half;
    logic             saturate;
    logic [REM_W-1:0] rem;
    logic [N-1:0]     part;
    logic [2*N-1:0]   rad;
  } stage_t;

  stage_t st [N+1];

  // Stage zero is the incoming item with an empty remainder and root.
  assign st[0].valid     = rad.valid;
  assign st[0].over_half = rad.over_half;
  assign st[0].saturate  = rad.saturate;
  assign st[0].rem       = '0;
  assign st[0].part      = '0;
  assign st[0].rad       = rad.radicand;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [REM_W:0]   rem_sh;
    logic [REM_W:0]   trial;
    logic [REM_W:0]   rem_sub;
    logic             take;

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_sh  = {st[k].rem[REM_W-2:0], st[k].rad[2*N-1:2*N-2]};
    assign trial   = {1'b0, st[k].part, 2'b01};
    assign rem_sub = rem_sh - trial;
    assign take    = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        st[k+1].valid <= 1'b0;
      end else begin
        st[k+1].valid <= st[k].valid;
      end
      st[k+1].over_half <= st[k].over_half;
      st[k+1].saturate  <= st[k].saturate;
      st[k+1].rad       <= {st[k].rad[2*N-3:0], 2'b00};
      if (take) begin
        st[k+1].rem  <= rem_sub[REM_W-1:0];
        st[k+1].part <= {st[k].part[N-2:0], 1'b1};
      end else begin
        st[k+1].rem  <= rem_sh[REM_W-1:0];
        st[k+1].part <= {st[k].part[N-2:0], 1'b0};
      end
    end
  end

  assign root.valid     = st[N].valid;
  assign root.over_half = st[N].over_half;
  assign root.saturate  = st[N].saturate;
  assign root.root      = st[N].part;

endmodule

FILE: hw/rtl/periodic_min_image_distance_unit.sv
// ----------------------------------------------------------------------------
// periodic_min_image_distance_unit
// Minimum-image distance between two points in a periodic cubic box.
// Pipeline: five front stages, one square-root stage per result bit and one
// output stage lie between the accepting edge and the result strobe.
// Throughput: one item per cycle outside reset, where busy is low; no stalls.
// Reset: synchronous; busy is high while reset is held, valid bits clear,
// and the period register returns to 1.0.
// ----------------------------------------------------------------------------
module periodic_min_image_distance_unit #(
  parameter int DIMENSIONS = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pmid_pkg::pmid_in_t  operands,
  output logic                done,
  output pmid_pkg::pmid_out_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  pmid_pkg::period_t   cfg_data
);

  pmid_pkg::period_t    period;
  pmid_pkg::pmid_rad_t  rad;
  pmid_pkg::pmid_root_t root;

  // An item can enter in every cycle outside reset.
  assign busy      = rst;
  assign cfg_ready = 1'b1;

  // Period register.
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= pmid_pkg::PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      period <= cfg_data;
    end
  end

  pmid_front #(
    .DIMENSIONS(DIMENSIONS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .in_item  (operands),
    .period   (period),
    .rad      (rad)
  );

  pmid_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .rad  (rad),
    .root (root)
  );

  // Output register; a root beyond the field width saturates.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= root.valid;
    end
  end

  always_ff @(posedge clk) begin
    result.distance  <= root.saturate ? '1 : root.root;
    result.over_half <= root.over_half;
  end

endmodule

FILE: hw/rtl/pmid_checker.sv
// ----------------------------------------------------------------------------
// pmid_checker
// Port-level checks of the distance unit: fixed latency from each accepted
// item to its result strobe, and readiness of both input channels.
// ----------------------------------------------------------------------------
module pmid_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic cfg_ready
);

  localparam int LAT   = pmid_pkg::LATENCY;
  localparam int CNT_W = $clog2(LAT + 2);

  logic [CNT_W-1:0] since_reset;

  // Cycles since reset was last held, saturating once the pipeline is full.
  always_ff @(posedge clk) begin
    if (rst) begin
      since_reset <= '0;
    end else if (since_reset != CNT_W'(LAT + 1)) begin
      since_reset <= since_reset + 1'b1;
    end
  end

  // Every strobe belongs to an item accepted a full latency earlier.
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result strobe without an accepted item");

  // Every item accepted without an intervening reset produces its strobe.
  a_item_gives_done: assert property (@(posedge clk) disable iff (rst)
    (since_reset == CNT_W'(LAT + 1)) && $past(start && !busy, LAT) |-> done)
    else $error("accepted item produced no result");

  // The unit takes an item in every cycle outside reset.
  a_never_busy: assert property (@(posedge clk)
    !rst |-> !busy)
    else $error("busy raised outside reset");

  // The configuration channel is always ready.
  a_cfg_ready: assert property (@(posedge clk)
    !rst |-> cfg_ready)
    else $error("configuration channel not ready");

endmodule

bind periodic_min_image_distance_unit pmid_checker u_checker (.*);
